// ===== rtl/core/acc_pkg.sv =====
// Package for the affine odd-map cycle search block.
// Holds widths, reset values, verdict codes and the step unit's result type.
// No dependencies.
package acc_pkg;
  localparam int OverflowShift = 120;
  localparam int ValW = 128;
  localparam int PeriodW = 40;
  localparam logic [PeriodW-1:0] PeriodMax = {PeriodW{1'b1}};

  localparam logic [6:0] QReset = 7'd3;
  localparam logic [31:0] DReset = 32'd1;
  localparam logic [31:0] StepLimitReset = 32'd20000;
  localparam logic [31:0] BrentLimitReset = 32'd50000000;

  localparam logic [1:0] RegQ = 2'd0;
  localparam logic [1:0] RegD = 2'd1;
  localparam logic [1:0] RegStepLimit = 2'd2;
  localparam logic [1:0] RegBrentLimit = 2'd3;

  localparam logic [2:0] VerdictNothing = 3'd0;
  localparam logic [2:0] VerdictCycle = 3'd1;
  localparam logic [2:0] VerdictEntered = 3'd2;
  localparam logic [2:0] VerdictUnresolved = 3'd3;
  localparam logic [2:0] VerdictOverflow = 3'd4;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [7:0] shift;
    logic ok;
  } step_res_t;

  function automatic logic at_limit(input logic [ValW-1:0] a);
    at_limit = a[ValW-1:OverflowShift] != '0;
  endfunction
endpackage

// ===== rtl/core/affine_collatz_cycle_search_top.sv =====
// Top level of the affine odd-map cycle search block.
// Depends on acc_pkg and acc_step_unit.
//
// Each accepted start value y follows x -> (q*x + d) >> ctz on odd values; each
// odd step goes through the ISSUE, WAIT and EVAL states and a single shared
// multiply, add and shift unit. The direct search takes up to step_limit steps;
// when it reaches the limit, Brent detection runs for a first hare step and up
// to brent_limit further steps, and the cycle found is walked once. The block
// takes no new beat until the result beat has been taken.
module affine_collatz_cycle_search_top
  import acc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata,   // start_value
  output logic m_tvalid,
  input  logic m_tready,
  // verdict[2:0], start_echo[66:3], total_period[106:67], odd_step_count[138:107],
  // value_low_word[202:139], value_high_word[258:203], zeros in [263:259]
  output logic [263:0] m_tdata
);
  typedef enum logic [2:0] {
    IDLE, ISSUE, WAIT, EVAL, DONE
  } state_t;
  typedef enum logic [1:0] {
    PH_DIRECT, PH_BRENT_FIRST, PH_BRENT, PH_WALK
  } phase_t;

  state_t state;
  phase_t phase;
  logic [6:0] q_multiplier;
  logic [31:0] d_offset, step_limit, brent_limit;
  logic [ValW-1:0] y, cur, largest, tortoise, hare, least;
  logic [32:0] brent_power, brent_lambda;
  logic [PeriodW-1:0] step_counter, halving_sum;
  logic [32:0] cnt;
  logic [2:0] verdict;
  logic [PeriodW-1:0] period;
  logic [31:0] odd;
  logic [ValW-1:0] val;
  logic step_start;
  logic [ValW-1:0] step_x;
  step_res_t res;
  logic [PeriodW:0] hs_sum;
  logic [PeriodW-1:0] hs_next;

  acc_step_unit u_step (
    .clk(clk), .start(step_start), .x(step_x),
    .q(q_multiplier), .d(d_offset), .res(res)
  );

  assign step_start = state == ISSUE;
  assign hs_sum = {1'b0, halving_sum} + {{(PeriodW-7){1'b0}}, res.shift};
  assign hs_next = hs_sum > {1'b0, PeriodMax} ? PeriodMax : hs_sum[PeriodW-1:0];
  assign s_tready = (state == IDLE) && !rst;
  assign m_tvalid = state == DONE;
  assign m_tdata = {5'd0, val[119:64], val[63:0], odd, period, y[63:0], verdict};

  always_comb begin
    unique case (phase)
      PH_DIRECT: step_x = cur;
      PH_BRENT_FIRST: step_x = tortoise;
      PH_BRENT: step_x = hare;
      PH_WALK: step_x = cur;
      default: step_x = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      phase <= PH_DIRECT;
      q_multiplier <= QReset;
      d_offset <= DReset;
      step_limit <= StepLimitReset;
      brent_limit <= BrentLimitReset;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegQ: q_multiplier <= cfg_data[6:0];
          RegD: d_offset <= cfg_data;
          RegStepLimit: step_limit <= cfg_data;
          RegBrentLimit: brent_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            y <= {64'd0, s_tdata};
            cur <= {64'd0, s_tdata};
            largest <= {64'd0, s_tdata};
            step_counter <= '0;
            halving_sum <= '0;
            verdict <= VerdictNothing;
            period <= '0;
            odd <= '0;
            val <= '0;
            phase <= PH_DIRECT;
            state <= ISSUE;
          end
        end
        ISSUE: state <= WAIT;
        WAIT: state <= EVAL;
        EVAL: begin
          state <= ISSUE;
          unique case (phase)
            PH_DIRECT: begin
              if (!res.ok) begin
                state <= DONE;
              end else begin
                cur <= res.value;
                step_counter <= step_counter + 1'b1;
                halving_sum <= hs_next;
                if (largest < res.value) largest <= res.value;
                if (res.value < y) begin
                  state <= DONE;
                end else if (res.value == y) begin
                  verdict <= VerdictCycle;
                  period <= hs_next;
                  odd <= step_counter[31:0] + 1'b1;
                  val <= largest < res.value ? res.value : largest;
                  state <= DONE;
                end else if (at_limit(res.value)) begin
                  verdict <= VerdictOverflow;
                  state <= DONE;
                end else if (step_counter + 1'b1 >= {8'd0, step_limit}) begin
                  tortoise <= res.value;
                  brent_power <= 33'd1;
                  brent_lambda <= 33'd1;
                  cnt <= '0;
                  phase <= PH_BRENT_FIRST;
                end
              end
            end
            PH_BRENT_FIRST, PH_BRENT: begin
              if (phase == PH_BRENT_FIRST) begin
                if (!res.ok) begin
                  verdict <= VerdictUnresolved;
                  state <= DONE;
                end else begin
                  hare <= res.value;
                  if (res.value == tortoise) begin
                    cur <= res.value;
                    least <= res.value;
                    largest <= res.value;
                    halving_sum <= '0;
                    step_counter <= '0;
                    phase <= PH_WALK;
                  end else begin
                    if (brent_power == brent_lambda) begin
                      tortoise <= res.value;
                      brent_power <= {brent_power[31:0], 1'b0};
                      brent_lambda <= '0;
                    end
                    phase <= PH_BRENT;
                  end
                end
              end else begin
                if (!res.ok || at_limit(hare) || cnt + 1'b1 > {1'b0, brent_limit}) begin
                  verdict <= VerdictUnresolved;
                  state <= DONE;
                end else begin
                  hare <= res.value;
                  cnt <= cnt + 1'b1;
                  if (res.value == tortoise) begin
                    brent_lambda <= brent_lambda + 1'b1;
                    cur <= res.value;
                    least <= res.value;
                    largest <= res.value;
                    halving_sum <= '0;
                    step_counter <= '0;
                    phase <= PH_WALK;
                  end else if (brent_power == brent_lambda + 1'b1) begin
                    tortoise <= res.value;
                    brent_power <= {brent_power[31:0], 1'b0};
                    brent_lambda <= '0;
                  end else begin
                    brent_lambda <= brent_lambda + 1'b1;
                  end
                end
              end
            end
            PH_WALK: begin
              logic [ValW-1:0] lo_n, hi_n;
              lo_n = res.value < least ? res.value : least;
              hi_n = largest < res.value ? res.value : largest;
              cur <= res.value;
              least <= lo_n;
              largest <= hi_n;
              halving_sum <= hs_next;
              step_counter <= step_counter + 1'b1;
              if (res.value == hare
                  || step_counter + 1'b1 >= {7'd0, brent_lambda}) begin
                state <= DONE;
                if (y < lo_n) begin
                  verdict <= VerdictEntered;
                  val <= lo_n;
                  period <= hs_next;
                  odd <= step_counter[31:0] + 1'b1;
                end else if (y == lo_n) begin
                  verdict <= VerdictCycle;
                  val <= hi_n;
                  period <= hs_next;
                  odd <= step_counter[31:0] + 1'b1;
                end
              end
            end
            default: state <= DONE;
          endcase
        end
        DONE: begin
          if (m_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/acc_step_unit.sv =====
// Shared odd-step unit: computes (q*x + d) >> ctz in two registered stages.
// Depends on acc_pkg.
module acc_step_unit
  import acc_pkg::*;
(
  input  logic clk,
  input  logic start,
  input  logic [ValW-1:0] x,
  input  logic [6:0] q,
  input  logic [31:0] d,
  output step_res_t res
);
  logic [ValW-1:0] sum;
  logic [ValW-1:0] prod;
  logic [ValW-1:0] shifted;
  logic [7:0] tz;
  logic found;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= x * {{(ValW-7){1'b0}}, q};
    end
  end

  assign sum = prod + {{(ValW-32){d[31]}}, d};

  always_comb begin
    tz = 8'd0;
    found = 1'b0;
    for (int i = 0; i < ValW; i++) begin
      if (!found && sum[i]) begin
        tz = 8'(i);
        found = 1'b1;
      end
    end
    shifted = sum >> tz;
  end

  always_ff @(posedge clk) begin
    res.ok <= !(sum[ValW-1] || sum == '0);
    res.value <= (sum[ValW-1] || sum == '0) ? '0 : shifted;
    res.shift <= tz;
  end
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for affine_collatz_cycle_search_top.
// Predicts each result in the testbench, checks every output beat against it and
// inserts random stalls on both streams. Depends on acc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top
  import acc_pkg::*;
;

  typedef struct {
    logic [2:0] verdict;
    logic [63:0] start;
    logic [39:0] period;
    logic [31:0] odd_steps;
    logic [119:0] value;
  } search_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegQ;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [263:0] m_tdata;

  logic [6:0] mult_q = QReset;
  logic [31:0] offset_d = DReset;
  logic [31:0] direct_limit = StepLimitReset;
  logic [31:0] hare_limit = BrentLimitReset;

  logic [63:0] starts_pending[$];
  search_result_t results_due[$];
  int errors = 0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int take_stall = 0;

  affine_collatz_cycle_search_top dut (.*);

  always #5 clk = ~clk;

  function automatic bit map_step(input logic [127:0] x, output logic [127:0] r,
                                  output int unsigned v);
    logic [127:0] s;
    s = x * {121'd0, mult_q} + {{96{offset_d[31]}}, offset_d};
    r = '0;
    v = 0;
    if (s[127] || s == '0) return 1'b0;
    while (!s[v]) v++;
    r = s >> v;
    return 1'b1;
  endfunction

  function automatic logic [63:0] add_period(input logic [63:0] a, input int unsigned v);
    logic [63:0] s;
    s = a + v;
    return (s > PeriodMax) ? {24'd0, PeriodMax} : s;
  endfunction

  function automatic bit too_big(input logic [127:0] a);
    return a[127:OverflowShift] != '0;
  endfunction

  function automatic search_result_t search_cycle(input logic [63:0] y_in);
    search_result_t r;
    logic [127:0] y, cur, big, nx, tort, hare, z, least;
    logic [63:0] period, steps, power, lambda, cnt;
    int unsigned v;
    bit to_brent, ok;
    y = {64'd0, y_in};
    r.verdict = VerdictNothing;
    r.start = y_in;
    r.period = '0;
    r.odd_steps = '0;
    r.value = '0;
    cur = y;
    big = y;
    steps = 0;
    period = 0;
    to_brent = 1'b0;
    forever begin
      if (!map_step(cur, nx, v)) break;
      cur = nx;
      steps++;
      period = add_period(period, v);
      if (nx > big) big = nx;
      if (nx < y) break;
      if (nx == y) begin
        r.verdict = VerdictCycle;
        r.period = period[39:0];
        r.odd_steps = steps[31:0];
        r.value = big[119:0];
        break;
      end
      if (too_big(nx)) begin
        r.verdict = VerdictOverflow;
        break;
      end
      if (steps >= direct_limit) begin
        to_brent = 1'b1;
        break;
      end
    end
    if (to_brent) begin
      tort = cur;
      power = 1;
      lambda = 1;
      cnt = 0;
      ok = map_step(tort, hare, v);
      while (ok && tort != hare) begin
        if (power == lambda) begin
          tort = hare;
          power = power << 1;
          lambda = 0;
        end
        if (!map_step(hare, nx, v) || too_big(hare)) begin
          ok = 1'b0;
          break;
        end
        hare = nx;
        lambda++;
        cnt++;
        if (cnt > hare_limit) begin
          ok = 1'b0;
          break;
        end
      end
      if (!ok) begin
        r.verdict = VerdictUnresolved;
      end else begin
        z = hare;
        least = hare;
        big = hare;
        period = 0;
        steps = 0;
        do begin
          void'(map_step(z, z, v));
          period = add_period(period, v);
          steps++;
          if (z < least) least = z;
          if (z > big) big = z;
        end while (z != hare && steps < lambda);
        if (y < least) begin
          r.verdict = VerdictEntered;
          r.value = least[119:0];
          r.period = period[39:0];
          r.odd_steps = steps[31:0];
        end else if (y == least) begin
          r.verdict = VerdictCycle;
          r.value = big[119:0];
          r.period = period[39:0];
          r.odd_steps = steps[31:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (s_tvalid && s_tready) results_due.push_back(search_cycle(s_tdata));
    if (!rst && !(s_tvalid && !s_tready)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 14) - 1;
        s_tvalid <= 1'b0;
      end else if (starts_pending.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= starts_pending.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    search_result_t e;
    if (m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, m_tdata);
      end else begin
        e = results_due.pop_front();
        if (m_tdata[2:0] != e.verdict) begin
          errors++;
          $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, m_tdata[2:0]);
        end
        if (m_tdata[66:3] != e.start) begin
          errors++;
          $display("%0t: start expected %h actual %h", $time, e.start, m_tdata[66:3]);
        end
        if (m_tdata[106:67] != e.period) begin
          errors++;
          $display("%0t: period expected %0d actual %0d", $time, e.period, m_tdata[106:67]);
        end
        if (m_tdata[138:107] != e.odd_steps) begin
          errors++;
          $display("%0t: odd steps expected %0d actual %0d", $time, e.odd_steps,
                   m_tdata[138:107]);
        end
        if (m_tdata[258:139] != e.value || m_tdata[263:259] != '0) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, e.value, m_tdata[263:139]);
        end
      end
    end
    if (!rst) begin
      if (take_stall > 0) begin
        take_stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        take_stall = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegQ: mult_q = val[6:0];
      RegD: offset_d = val;
      RegStepLimit: direct_limit = val;
      default: hare_limit = val;
    endcase
  endtask

  task automatic configure(input logic [6:0] q, input logic [31:0] d,
                           input logic [31:0] sl, input logic [31:0] bl);
    write_reg(RegQ, {25'd0, q});
    write_reg(RegD, d);
    write_reg(RegStepLimit, sl);
    write_reg(RegBrentLimit, bl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (starts_pending.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [63:0] random_start();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 1000)) * 2 + 1;
      1: return {$urandom, $urandom} | 64'd1;
      2: return {$urandom, $urandom | 32'd1};
      default: return 64'($urandom_range(1, 500));
    endcase
  endfunction

  function automatic logic [31:0] random_offset();
    logic [31:0] d;
    if ($urandom_range(0, 4) == 0) d = $urandom;
    else d = 32'($urandom_range(0, 400)) - 32'd200;
    if ($urandom_range(0, 5) != 0) d[0] = 1'b1;
    return d;
  endfunction

  initial begin
    logic [6:0] q;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    starts_pending = '{64'd1, 64'd3, 64'd7, 64'd27, 64'd2, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF};
    wait_idle();

    configure(7'd127, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    starts_pending = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd6};
    wait_idle();

    configure(7'd1, 32'h8000_0000, 32'd1, 32'd100);
    starts_pending = '{64'd1, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001};
    wait_idle();

    configure(7'd3, 32'd1, 32'd1, 32'hFFFF_FFFF);
    starts_pending = '{64'd1, 64'd3, 64'd27, 64'd4};
    wait_idle();

    configure(7'd3, 32'hFFFF_FFFF, 32'd2, 32'd500);
    starts_pending = '{64'd5, 64'd17, 64'd4, 64'd9};
    wait_idle();

    configure(7'd5, 32'd1, 32'd4, 32'd3);
    starts_pending = '{64'd3, 64'd7, 64'd13};
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 4))
        0: q = 7'd1;
        1: q = 7'd3;
        2: q = 7'd5;
        3: q = 7'($urandom_range(0, 63) * 2 + 1);
        default: q = 7'($urandom_range(1, 127));
      endcase
      configure(q, random_offset(), 32'($urandom_range(1, 64)), 32'($urandom_range(0, 3000)));
      if (ph == 6) quiet = 1'b1;
      for (int i = 0; i < 11; i++) starts_pending.push_back(random_start());
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
